FILE: src/cmac_pkg.sv
// ----------------------------------------------------------------------------
// cmac_pkg
// shared types, constants and aes helper functions for the cmac tag engine
// ----------------------------------------------------------------------------
package cmac_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int COUNT_W = 5;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    localparam logic [7:0]   RB_CONST  = 8'h87;
    localparam logic [7:0]   PAD_BYTE  = 8'h80;
    localparam logic [4:0]   FULL_BYTES = 5'd16;

    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        logic [COUNT_W-1:0] byte_count;
        logic               msg_end;
        logic               operation;
        logic [BLOCK_W-1:0] expected;
    } cmac_item_t;

    typedef logic [7:0] byte_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        unique case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic byte_t get_byte(input logic [BLOCK_W-1:0] b, input int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

    // one aes round: subbytes, shiftrows, optional mixcolumns, add round key
    function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                     input logic [BLOCK_W-1:0] rk,
                                                     input logic final_rnd);
        byte_t t [16];
        byte_t a0, a1, a2, a3, al;
        logic [BLOCK_W-1:0] o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r+4*c] = sbox(get_byte(s, r + 4*((c+r) & 3)));
        if (!final_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        o = '0;
        for (int i = 0; i < 16; i++)
            o[BLOCK_W-1-8*i -: 8] = t[i];
        return o ^ rk;
    endfunction

    // next round key from the current one
    function automatic logic [BLOCK_W-1:0] key_step(input logic [BLOCK_W-1:0] k,
                                                    input byte_t rc);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [BLOCK_W-1:0] dbl(input logic [BLOCK_W-1:0] x);
        return {x[BLOCK_W-2:0], 1'b0} ^ (x[BLOCK_W-1] ? {120'd0, RB_CONST} : '0);
    endfunction

endpackage

FILE: src/cmac_front.sv
// ----------------------------------------------------------------------------
// cmac_front
// input side: takes items and keeps them in a short queue for the back end
// ----------------------------------------------------------------------------
module cmac_front
    import cmac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  cmac_item_t item_in,
    output logic       item_valid,
    output cmac_item_t item_out,
    input  logic       item_take
);

    cmac_item_t  mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        wr, rd;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign wr         = push && !full;
    assign rd         = item_take && item_valid;
    assign item_out   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

FILE: src/cmac_back.sv
// ----------------------------------------------------------------------------
// cmac_back
// execution side: iterative aes core, subkey derivation, chaining and tag out
// ----------------------------------------------------------------------------
module cmac_back
    import cmac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [BLOCK_W-1:0] key,
    input  logic               key_wr,
    input  logic               item_valid,
    input  cmac_item_t         item,
    output logic               item_take,
    output logic               empty,
    input  logic               pop,
    output logic [BLOCK_W-1:0] tag,
    output logic               status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DERIV = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0]         state_reg;
    logic [3:0]         round_reg;
    logic [BLOCK_W-1:0] s_reg, rk_reg;
    logic [7:0]         rc_reg;
    logic [BLOCK_W-1:0] chain_reg, k1_reg, k2_reg;
    logic               ready_reg;
    logic               last_reg, op_reg;
    logic [BLOCK_W-1:0] exp_reg;
    logic               ovalid_reg;
    logic [BLOCK_W-1:0] otag_reg;
    logic               ostat_reg;

    logic [BLOCK_W-1:0] rk_nx, s_nx, blk_in, padded, mask;
    logic               start, out_free;
    logic [3:0]         cnt;

    assign rk_nx    = key_step(rk_reg, rc_reg);
    assign s_nx     = aes_round(s_reg, rk_nx, round_reg == 4'd10);
    assign out_free = !ovalid_reg || pop;
    // only a final block needs the output register
    assign start    = (state_reg == ST_IDLE) && ready_reg && item_valid
                      && (out_free || !item.msg_end);
    assign item_take = start;
    assign empty    = !ovalid_reg;
    assign tag      = otag_reg;
    assign status   = ostat_reg;

    // pad a short block: keep count bytes, then 0x80, then zeros
    assign cnt = item.byte_count[3:0];
    always_comb
    begin
        mask = '0;
        for (int i = 0; i < 16; i++)
            if (i < int'(cnt))
                mask[BLOCK_W-1-8*i -: 8] = 8'hff;
        padded = (item.blk & mask) | ({PAD_BYTE, 120'd0} >> {cnt, 3'b000});
        if (!item.msg_end)
            blk_in = item.blk;
        else if (item.byte_count >= FULL_BYTES)
            blk_in = item.blk ^ k1_reg;
        else
            blk_in = padded ^ k2_reg;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rk_reg <= key;
                rc_reg <= 8'h01;
                if (!ready_reg)
                    s_reg <= key;
                else
                    s_reg <= chain_reg ^ blk_in ^ key;
                last_reg <= item.msg_end;
                op_reg   <= item.operation;
                exp_reg  <= item.expected;
            end
            default:
            begin
                s_reg  <= s_nx;
                rk_reg <= rk_nx;
                rc_reg <= xtime(rc_reg);
            end
        endcase
        if (state_reg == ST_DERIV && round_reg == 4'd10)
        begin
            k1_reg <= dbl(s_nx);
            k2_reg <= dbl(dbl(s_nx));
        end
        if (state_reg == ST_RUN && round_reg == 4'd10 && last_reg)
        begin
            otag_reg  <= s_nx;
            ostat_reg <= op_reg && (s_nx != exp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            round_reg  <= 4'd0;
            ready_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            chain_reg  <= '0;
        end
        else
        begin
            if (pop && ovalid_reg)
                ovalid_reg <= 1'b0;
            // chain returns to zero after each message
            if (state_reg == ST_RUN && round_reg == 4'd10)
                chain_reg <= last_reg ? '0 : s_nx;
            unique case (state_reg)
                ST_IDLE:
                begin
                    round_reg <= 4'd1;
                    if (!ready_reg && item_valid)
                        state_reg <= ST_DERIV;
                    else if (start)
                        state_reg <= ST_RUN;
                end
                ST_DERIV:
                begin
                    round_reg <= round_reg + 4'd1;
                    if (round_reg == 4'd10)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_RUN:
                begin
                    round_reg <= round_reg + 4'd1;
                    if (round_reg == 4'd10)
                    begin
                        state_reg <= ST_IDLE;
                        if (last_reg)
                            ovalid_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (key_wr)
                ready_reg <= 1'b0;
        end
    end

endmodule

FILE: src/aes128_cmac_tag_engine_unit.sv
// ----------------------------------------------------------------------------
// aes128_cmac_tag_engine_unit
// aes-128 cmac tag generation and validation
//
// channel   | direction | handshake        | payload
// input     | in        | push / full      | operation, block, byte_count, msg_end, expected
// result    | out       | empty / pop      | tag_high, tag_low, status
// config    | in        | cfg_we           | cfg_index, cfg_data (key halves)
//
// each block is loaded in the idle state, then runs ten rounds in the
// round-iterative aes unit, round keys made on the fly alongside
// the first block after reset or a key write waits first for subkey derivation
// a two-entry input queue takes the next transfer while the core is busy
// a waiting tag holds only the next final block, until the tag is popped
// ----------------------------------------------------------------------------
module aes128_cmac_tag_engine_unit
    import cmac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                operation,
    input  logic [HALF_W-1:0]   block_high,
    input  logic [HALF_W-1:0]   block_low,
    input  logic [COUNT_W-1:0]  byte_count,
    input  logic                msg_end,
    input  logic [HALF_W-1:0]   expected_high,
    input  logic [HALF_W-1:0]   expected_low,
    output logic                empty,
    input  logic                pop,
    output logic [HALF_W-1:0]   tag_high,
    output logic [HALF_W-1:0]   tag_low,
    output logic                status,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [HALF_W-1:0]   cfg_data
);

    logic [HALF_W-1:0]  key_high_reg, key_low_reg;
    cmac_item_t         item_in, item_q;
    logic               item_valid, item_take;
    logic [BLOCK_W-1:0] tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    assign item_in = '{blk: {block_high, block_low}, byte_count: byte_count,
                       msg_end: msg_end, operation: operation,
                       expected: {expected_high, expected_low}};

    cmac_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_out   (item_q),
        .item_take  (item_take)
    );

    cmac_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        ({key_high_reg, key_low_reg}),
        .key_wr     (cfg_we),
        .item_valid (item_valid),
        .item       (item_q),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .tag        (tag),
        .status     (status)
    );

    assign tag_high = tag[BLOCK_W-1:HALF_W];
    assign tag_low  = tag[HALF_W-1:0];

endmodule
